[rtl/lsp_pkg.sv]
package lsp_pkg;

   // Widths of the item, result and register fields.
   localparam int COUNT_W   = 7;
   localparam int COLOR_W   = 8;
   localparam int SELECT_W  = 3;
   localparam int LEVEL_W   = 4;
   localparam int POS_W     = 5;
   localparam int SIZE_W    = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 7;

   // Built-in pattern tables.
   localparam int TABLE_ROWS = 6;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_SELECT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRING_LENGTH  = 2'd2;

   // Register reset values.
   localparam logic [SELECT_W-1:0]  SELECT_RESET = 3'd1;
   localparam logic [LEVEL_W-1:0]   LEVEL_RESET  = 4'd8;
   localparam logic [COUNT_W-1:0]   LENGTH_RESET = 7'd18;
   localparam logic [LEVEL_W-1:0]   LEVEL_FULL   = 4'd8;

   localparam logic OPCODE_TICK = 1'b0;
   localparam logic OPCODE_FILL = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [COUNT_W-1:0] fill_count;
      logic [COLOR_W-1:0] fill_red;
      logic [COLOR_W-1:0] fill_green;
      logic [COLOR_W-1:0] fill_blue;
   } req_payload_type;

   typedef struct packed {
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] blue;
      logic               last_led;
   } rsp_payload_type;

   // Microprogram steps.
   typedef logic [2:0] step_type;
   localparam step_type STEP_WAIT       = 3'd0;
   localparam step_type STEP_DECODE     = 3'd1;
   localparam step_type STEP_TICK_CHECK = 3'd2;
   localparam step_type STEP_TICK_INIT  = 3'd3;
   localparam step_type STEP_FILL_INIT  = 3'd4;
   localparam step_type STEP_FILL_CHECK = 3'd5;
   localparam step_type STEP_EMIT       = 3'd6;
   localparam step_type STEP_DONE       = 3'd7;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_ACCEPT,
      COND_FILL,
      COND_NO_PATTERN,
      COND_EMPTY,
      COND_LAST
   } cond_type;

   // Datapath controls carried in one microword.
   typedef struct packed {
      logic req_ready;
      logic load_item;
      logic init_tick;
      logic init_fill;
      logic emit;
      logic advance_pos;
   } ctl_type;

   typedef struct packed {
      ctl_type  ctl;
      cond_type cond;
      logic     hold;
      step_type target;
   } uword_type;

   // Datapath flags tested by the jump conditions.
   typedef struct packed {
      logic accept;
      logic is_fill;
      logic no_pattern;
      logic count_zero;
      logic last_fire;
   } status_type;

   function automatic logic [SIZE_W-1:0] pat_len(input logic [SELECT_W-1:0] row);
      logic [SIZE_W-1:0] len;
      case (row)
         3'd0:    len = 6'd1;
         3'd1:    len = 6'd1;
         3'd2:    len = 6'd8;
         3'd3:    len = 6'd4;
         3'd4:    len = 6'd22;
         3'd5:    len = 6'd2;
         default: len = 6'd1;
      endcase
      return len;
   endfunction

   // Table entry as {red, green, blue}.
   function automatic logic [3*COLOR_W-1:0] pat_rgb(input logic [SELECT_W-1:0] row,
                                                    input logic [POS_W-1:0] slot);
      logic [3*COLOR_W-1:0] rgb;
      rgb = '0;
      case (row)
         3'd1: begin
            if (slot == 5'd0) rgb = 24'hffffff;
         end
         3'd2: begin
            case (slot)
               5'd0:    rgb = 24'hffffff;
               5'd1:    rgb = 24'hffff00;
               5'd2:    rgb = 24'hff00ff;
               5'd3:    rgb = 24'h00ffff;
               5'd4:    rgb = 24'hff0000;
               5'd5:    rgb = 24'h00ff00;
               5'd6:    rgb = 24'h0000ff;
               5'd7:    rgb = 24'h00ff00;
               default: rgb = '0;
            endcase
         end
         3'd3: begin
            case (slot)
               5'd0, 5'd1: rgb = 24'h780000;
               5'd2, 5'd3: rgb = 24'h007800;
               default:    rgb = '0;
            endcase
         end
         3'd4: begin
            // Each level of the fade is held for two LEDs.
            case (slot[4:1])
               4'd0:    rgb = 24'hc8ed9b;
               4'd1:    rgb = 24'h97b27e;
               4'd2:    rgb = 24'h768c64;
               4'd3:    rgb = 24'h5b6b4d;
               4'd4:    rgb = 24'h434f39;
               4'd5:    rgb = 24'h30392a;
               4'd6:    rgb = 24'h21271d;
               4'd7:    rgb = 24'h151913;
               4'd8:    rgb = 24'h0c0e0b;
               4'd9:    rgb = 24'h060704;
               4'd10:   rgb = 24'h010201;
               default: rgb = '0;
            endcase
         end
         3'd5: begin
            case (slot)
               5'd0:    rgb = 24'hff0000;
               5'd1:    rgb = 24'h0000ff;
               default: rgb = '0;
            endcase
         end
         default: rgb = '0;
      endcase
      return rgb;
   endfunction

endpackage

[rtl/lsp_stream_if.sv]
interface lsp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/lsp_sequencer.sv]
module lsp_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  lsp_pkg::status_type sts,
   output lsp_pkg::ctl_type    ctl
);
   import lsp_pkg::*;

   step_type  step_ff;
   step_type  step_in;
   uword_type word;
   logic      taken;

   // The control store: one microword per step.
   function automatic uword_type ucode(input step_type s);
      uword_type w;
      w = '0;
      w.cond = COND_NONE;
      case (s)
         STEP_WAIT: begin
            w.ctl.req_ready = 1'b1;
            w.ctl.load_item = 1'b1;
            w.cond          = COND_ACCEPT;
            w.hold          = 1'b1;
            w.target        = STEP_DECODE;
         end
         STEP_DECODE: begin
            w.cond   = COND_FILL;
            w.target = STEP_FILL_INIT;
         end
         STEP_TICK_CHECK: begin
            w.cond   = COND_NO_PATTERN;
            w.target = STEP_WAIT;
         end
         STEP_TICK_INIT: begin
            w.ctl.init_tick = 1'b1;
            w.cond          = COND_ALWAYS;
            w.target        = STEP_EMIT;
         end
         STEP_FILL_INIT: begin
            w.ctl.init_fill = 1'b1;
         end
         STEP_FILL_CHECK: begin
            w.cond   = COND_EMPTY;
            w.target = STEP_WAIT;
         end
         STEP_EMIT: begin
            w.ctl.emit = 1'b1;
            w.cond     = COND_LAST;
            w.hold     = 1'b1;
            w.target   = STEP_DONE;
         end
         STEP_DONE: begin
            w.ctl.advance_pos = 1'b1;
            w.cond            = COND_ALWAYS;
            w.target          = STEP_WAIT;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      word = ucode(step_ff);
      ctl  = word.ctl;
      case (word.cond)
         COND_ALWAYS:     taken = 1'b1;
         COND_ACCEPT:     taken = sts.accept;
         COND_FILL:       taken = sts.is_fill;
         COND_NO_PATTERN: taken = sts.no_pattern;
         COND_EMPTY:      taken = sts.count_zero;
         COND_LAST:       taken = sts.last_fire;
         default:         taken = 1'b0;
      endcase
      if (taken) begin
         step_in = word.target;
      end else if (word.hold) begin
         step_in = step_ff;
      end else begin
         step_in = step_ff + 3'd1;
      end
   end

endmodule

[rtl/lsp_datapath.sv]
module lsp_datapath #(
   parameter int MAX_LEDS      = 64,
   parameter int PATTERN_DEPTH = 24,
   parameter int PATTERN_COUNT = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [lsp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lsp_pkg::CSR_DAT_W-1:0]     csr_wdata,
   lsp_stream_if.sink                        req_ch,
   lsp_stream_if.source                      rsp_ch,
   input  lsp_pkg::ctl_type                  ctl,
   output lsp_pkg::status_type               sts
);
   import lsp_pkg::*;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_LEDS);
   localparam logic [SIZE_W-1:0]  MAX_SIZE  = SIZE_W'(PATTERN_DEPTH);

   // Configuration registers and pattern state.
   logic [SELECT_W-1:0] select_ff, select_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [COUNT_W-1:0]  length_ff, length_in;
   logic [POS_W-1:0]    pos_ff, pos_in;

   // Item and frame counters.
   req_payload_type     item_ff, item_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [POS_W-1:0]    idx_ff, idx_in;

   // Output register.
   logic                out_valid_ff, out_valid_in;
   rsp_payload_type     out_ff, out_in;

   logic                accept;
   logic                fire;
   logic                no_pattern;
   logic [SELECT_W-1:0] row;
   logic [SIZE_W-1:0]   len;
   logic [SIZE_W-1:0]   size;
   logic [LEVEL_W-1:0]  shift;
   logic [3*COLOR_W-1:0] rgb;
   logic [SIZE_W-1:0]   idx_inc;
   logic [SIZE_W-1:0]   pos_inc;
   logic [COUNT_W-1:0]  fill_n;
   logic [COUNT_W-1:0]  tick_n;

   assign req_ch.ready   = ctl.req_ready;
   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         select_ff    <= SELECT_RESET;
         level_ff     <= LEVEL_RESET;
         length_ff    <= LENGTH_RESET;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         select_ff    <= select_in;
         level_ff     <= level_in;
         length_ff    <= length_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      count_ff <= count_in;
      idx_ff   <= idx_in;
      out_ff   <= out_in;
   end

   always_comb begin
      accept     = req_ch.valid && ctl.req_ready;
      fire       = ctl.emit && (!out_valid_ff || rsp_ch.ready);

      no_pattern = (select_ff == '0) ||
                   (32'(select_ff) > PATTERN_COUNT) ||
                   (32'(select_ff) > TABLE_ROWS);
      row        = select_ff - 3'd1;
      len        = pat_len(row);
      size       = (len > MAX_SIZE) ? MAX_SIZE : len;
      if (size == '0) size = 6'd1;

      shift      = (level_ff > LEVEL_FULL) ? 4'd0 : LEVEL_FULL - level_ff;
      rgb        = pat_rgb(row, idx_ff);

      idx_inc    = {1'b0, idx_ff} + 6'd1;
      pos_inc    = {1'b0, pos_ff} + 6'd1;
      fill_n     = (item_ff.fill_count > MAX_COUNT) ? MAX_COUNT : item_ff.fill_count;
      tick_n     = (length_ff > MAX_COUNT) ? MAX_COUNT : length_ff;

      sts.accept     = accept;
      sts.is_fill    = (item_ff.opcode == OPCODE_FILL);
      sts.no_pattern = no_pattern;
      sts.count_zero = (count_ff == '0);
      sts.last_fire  = fire && (count_ff == 7'd1);

      select_in = select_ff;
      level_in  = level_ff;
      length_in = length_ff;
      pos_in    = pos_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_SELECT: begin
               select_in = csr_wdata[SELECT_W-1:0];
               pos_in    = '0;
            end
            CSR_BRIGHTNESS: level_in = csr_wdata[LEVEL_W-1:0];
            CSR_STRING_LENGTH: begin
               length_in = (csr_wdata == '0) ? LENGTH_RESET : csr_wdata;
            end
            default: ;
         endcase
      end
      // The position moves on once per completed pattern frame.
      if (ctl.advance_pos && item_ff.opcode == OPCODE_TICK) begin
         pos_in = (pos_inc >= size) ? '0 : pos_inc[POS_W-1:0];
      end

      item_in = item_ff;
      if (ctl.load_item && accept) begin
         item_in = req_ch.payload;
      end

      count_in = count_ff;
      idx_in   = idx_ff;
      if (ctl.init_tick) begin
         count_in = tick_n;
         idx_in   = pos_ff;
      end
      if (ctl.init_fill) begin
         count_in = fill_n;
      end

      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_in       = out_ff;
      if (fire) begin
         out_valid_in = 1'b1;
         count_in     = count_ff - 7'd1;
         idx_in       = (idx_inc >= size) ? '0 : idx_inc[POS_W-1:0];
         out_in.last_led = (count_ff == 7'd1);
         if (item_ff.opcode == OPCODE_FILL) begin
            out_in.red   = item_ff.fill_red;
            out_in.green = item_ff.fill_green;
            out_in.blue  = item_ff.fill_blue;
         end else begin
            out_in.red   = rgb[3*COLOR_W-1:2*COLOR_W] >> shift;
            out_in.green = rgb[2*COLOR_W-1:COLOR_W] >> shift;
            out_in.blue  = rgb[COLOR_W-1:0] >> shift;
         end
      end
   end

endmodule

[rtl/led_strip_pattern_generator.sv]
// Generates LED strip color words from built-in pattern tables or a solid fill.
// req_ch takes one item per transfer: a pattern tick (opcode 0) or a solid
// fill (opcode 1 with fill_count and a fill color). rsp_ch carries one LED
// word per transfer, green, red and blue bytes, with last_led set on the
// final word of the item. The csr_ port writes pattern_select (0),
// brightness (1) and string_length (2); write only while the block is idle.
// A tick runs the decode, tick check and tick init steps and a fill the
// decode, fill init and fill check steps; the emit step then registers the
// first word. A tick with the pattern off or an empty fill returns to the
// wait step with no word. The microcoded sequencer emits from its emit step
// one word per cycle unless rsp_ch stalls and takes items only in its wait step.
// Reset restores pattern 1, full brightness, 18 LEDs and position zero.
// The output register holds a word while rsp_ch is stalled and the emit
// step waits; a new item can be taken while the last word still waits.
module led_strip_pattern_generator #(
   parameter int MAX_LEDS      = 64,
   parameter int PATTERN_DEPTH = 24,
   parameter int PATTERN_COUNT = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [lsp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lsp_pkg::CSR_DAT_W-1:0] csr_wdata,
   lsp_stream_if.sink                    req_ch,
   lsp_stream_if.source                  rsp_ch
);
   import lsp_pkg::*;

   ctl_type    ctl;
   status_type sts;

   lsp_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctl   (ctl)
   );

   lsp_datapath #(
      .MAX_LEDS      (MAX_LEDS),
      .PATTERN_DEPTH (PATTERN_DEPTH),
      .PATTERN_COUNT (PATTERN_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .ctl       (ctl),
      .sts       (sts)
   );

endmodule
